@@ src/lcdf_pkg.sv @@
// Shared types and constants for the three-wire LCD serial framer.
// No dependencies; used by every module of the block.
`default_nettype none
package lcdf_pkg;

    // Request operation codes
    localparam logic [1:0] OP_TICK    = 2'd0;
    localparam logic [1:0] OP_COMMAND = 2'd1;
    localparam logic [1:0] OP_WRITE   = 2'd2;
    localparam logic [1:0] OP_BURST   = 2'd3;

    // Result kinds
    localparam logic KIND_BIT  = 1'b0;
    localparam logic KIND_BUSY = 1'b1;

    // Frame prefixes, sent first
    localparam logic [3:0] CMD_PREFIX   = 4'b1000;
    localparam logic [2:0] WRITE_PREFIX = 3'b101;

    // Frame lengths in bits
    localparam logic [7:0] CMD_LEN    = 8'd12;
    localparam logic [7:0] WRITE_LEN  = 8'd13;
    localparam logic [7:0] BURST_HDR  = 8'd9;

    // Largest byte count whose frame length fits the 8-bit counter
    localparam int unsigned COUNTER_BYTE_LIMIT = 30;

    localparam int unsigned SHIFT_W = 13;
    localparam int unsigned LEN_W   = 8;

    // Decoded request passed from front to back
    typedef struct packed {
        logic [1:0]         op;
        logic [SHIFT_W-1:0] header;
        logic [LEN_W-1:0]   length;
    } t_req;

endpackage
`default_nettype wire

@@ src/lcdf_front.sv @@
// Front end: decodes an input item into a ready-to-load frame (header and length).
// Depends on lcdf_pkg.
`default_nettype none
module lcdf_front #(
    parameter int unsigned MAX_BURST_BYTES = 16
) (
    input  wire logic [1:0] i_op,
    input  wire logic [7:0] i_command_code,
    input  wire logic [5:0] i_ram_address,
    input  wire logic [3:0] i_nibble,
    input  wire logic [4:0] i_byte_count,
    output lcdf_pkg::t_req  o_req
);

    // byte count ceiling: parameter, then counter limit
    localparam int unsigned BYTE_LIMIT =
        (MAX_BURST_BYTES < lcdf_pkg::COUNTER_BYTE_LIMIT) ?
        MAX_BURST_BYTES : lcdf_pkg::COUNTER_BYTE_LIMIT;

    logic [4:0] w_count;

    // saturate burst length
    always_comb begin
        if (i_byte_count > 5'(BYTE_LIMIT)) begin
            w_count = 5'(BYTE_LIMIT);
        end else begin
            w_count = i_byte_count;
        end
    end

    // build header and length per operation
    always_comb begin
        o_req.op = i_op;
        unique case (i_op)
            lcdf_pkg::OP_COMMAND: begin
                o_req.header = {lcdf_pkg::CMD_PREFIX, i_command_code, 1'b0};
                o_req.length = lcdf_pkg::CMD_LEN;
            end
            lcdf_pkg::OP_WRITE: begin
                o_req.header = {lcdf_pkg::WRITE_PREFIX, i_ram_address, i_nibble};
                o_req.length = lcdf_pkg::WRITE_LEN;
            end
            lcdf_pkg::OP_BURST: begin
                o_req.header = {lcdf_pkg::WRITE_PREFIX, i_ram_address, 4'b0000};
                o_req.length = lcdf_pkg::BURST_HDR + {w_count, 3'b000};
            end
            default: begin
                // tick: payload unused
                o_req.header = '0;
                o_req.length = '0;
            end
        endcase
    end

endmodule
`default_nettype wire

@@ src/lcdf_queue.sv @@
// Two-entry queue of decoded requests between front and back.
// Depends on lcdf_pkg.
`default_nettype none
module lcdf_queue (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_push,
    input  wire lcdf_pkg::t_req i_req,
    output logic           o_ready,
    input  wire logic      i_pop,
    output logic           o_valid,
    output lcdf_pkg::t_req o_req
);

    lcdf_pkg::t_req r_mem [2];
    logic [1:0] r_count, n_count;
    logic       r_wr_ptr, r_rd_ptr;
    logic       w_push, w_pop;

    assign o_ready = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_req   = r_mem[r_rd_ptr];
    assign w_push  = i_push && o_ready;
    assign w_pop   = i_pop && o_valid;

    // occupancy
    always_comb begin
        n_count = r_count;
        if (w_push && !w_pop) begin
            n_count = r_count + 2'd1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 2'd1;
        end
    end

    // pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= 2'd0;
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_push) r_wr_ptr <= ~r_wr_ptr;
            if (w_pop)  r_rd_ptr <= ~r_rd_ptr;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wr_ptr] <= i_req;
    end

endmodule
`default_nettype wire

@@ src/lcdf_engine.sv @@
// Back end: holds the frame shift register, bit counter and busy flag, and
// drives the registered result. Depends on lcdf_pkg.
`default_nettype none
module lcdf_engine (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_valid,
    input  wire lcdf_pkg::t_req i_req,
    output logic           o_pop,
    output logic           o_valid,
    input  wire logic      i_ready,
    output logic           o_kind,
    output logic           o_data_bit,
    output logic           o_frame_last
);

    logic [lcdf_pkg::SHIFT_W-1:0] r_shift, n_shift;
    logic [lcdf_pkg::LEN_W-1:0]   r_remaining, n_remaining;
    logic                         r_busy, n_busy;
    logic                         r_out_valid, n_out_valid;
    logic                         r_kind, n_kind;
    logic                         r_bit, n_bit;
    logic                         r_last, n_last;
    logic [lcdf_pkg::LEN_W-1:0]   w_rem_dec;

    // take a request when the result slot is free or draining
    assign o_pop     = i_valid && (!r_out_valid || i_ready);
    assign w_rem_dec = r_remaining - 8'd1;

    // execute one queued request
    always_comb begin
        n_shift     = r_shift;
        n_remaining = r_remaining;
        n_busy      = r_busy;
        n_kind      = r_kind;
        n_bit       = r_bit;
        n_last      = r_last;
        n_out_valid = r_out_valid && !i_ready;
        if (o_pop) begin
            if (i_req.op == lcdf_pkg::OP_TICK) begin
                if (r_busy) begin
                    n_out_valid = 1'b1;
                    n_kind      = lcdf_pkg::KIND_BIT;
                    n_bit       = r_shift[lcdf_pkg::SHIFT_W-1];
                    n_last      = (w_rem_dec == '0);
                    n_shift     = {r_shift[lcdf_pkg::SHIFT_W-2:0], 1'b0};
                    n_remaining = w_rem_dec;
                    n_busy      = (w_rem_dec != '0);
                end
            end else if (r_busy) begin
                // request while a frame is running
                n_out_valid = 1'b1;
                n_kind      = lcdf_pkg::KIND_BUSY;
                n_bit       = 1'b0;
                n_last      = 1'b0;
            end else begin
                n_shift     = i_req.header;
                n_remaining = i_req.length;
                n_busy      = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift     <= '0;
            r_remaining <= '0;
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_shift     <= n_shift;
            r_remaining <= n_remaining;
            r_busy      <= n_busy;
            r_out_valid <= n_out_valid;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        r_kind <= n_kind;
        r_bit  <= n_bit;
        r_last <= n_last;
    end

    assign o_valid      = r_out_valid;
    assign o_kind       = r_kind;
    assign o_data_bit   = r_bit;
    assign o_frame_last = r_last;

    // counter and busy flag agree
    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> (r_remaining == '0))
        else $error("idle with bits outstanding");

    a_busy_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_remaining != '0))
        else $error("busy with empty counter");

    // a busy rejection carries no bit and no frame end
    a_reject_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_kind == lcdf_pkg::KIND_BUSY) |-> (!r_bit && !r_last))
        else $error("rejection with payload");

    // the final bit frees the framer
    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_req.op == lcdf_pkg::OP_TICK && r_busy && r_remaining == 8'd1)
        |=> (!r_busy && r_out_valid && r_last))
        else $error("final bit did not end frame");

endmodule
`default_nettype wire

@@ src/lcd_driver_serial_framer.sv @@
// Top level of the three-wire LCD serial framer: front decoder, request queue
// and framing engine. Depends on lcdf_pkg, lcdf_front, lcdf_queue, lcdf_engine.
//
// Usage: input items on the slave stream carry an operation (tick, command
// frame, write-nibble frame, burst-clear frame) and its fields. A frame request
// while idle loads the framer and gives no result; each following tick item
// gives one result with the next data bit, MSB first, and tlast on the final
// bit of the frame. A frame request while a
// frame runs gives one result with tuser set (busy) and leaves the frame alone.
// A tick while idle gives nothing.
// Throughput: one item per cycle while the receiver takes results; the
// decoder, a two-entry queue and the framing engine each handle one item per
// clock. With the queue empty, an accepted item is written into the queue
// entry, then the engine takes it from there and registers its result.
// Reset clears the queue, the framer and the output valid flag. When the
// receiver stalls, the held result blocks the engine and the queue fills;
// tready drops once both queue entries are occupied.
`default_nettype none
module lcd_driver_serial_framer #(
    parameter int unsigned MAX_BURST_BYTES = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    // op[1:0], command_code[9:2], ram_address[15:10], nibble[19:16],
    // byte_count[24:20], zeros above
    input  wire logic [31:0] i_s_tdata,
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    // data_bit[0], zeros above
    output logic [7:0]       o_m_tdata,
    output logic             o_m_tlast,
    // kind[0]
    output logic             o_m_tuser
);

    lcdf_pkg::t_req w_dec_req;
    lcdf_pkg::t_req w_q_req;
    logic           w_q_valid;
    logic           w_pop;
    logic           w_bit;

    // classify the incoming item
    lcdf_front #(
        .MAX_BURST_BYTES (MAX_BURST_BYTES)
    ) u_front (
        .i_op           (i_s_tdata[1:0]),
        .i_command_code (i_s_tdata[9:2]),
        .i_ram_address  (i_s_tdata[15:10]),
        .i_nibble       (i_s_tdata[19:16]),
        .i_byte_count   (i_s_tdata[24:20]),
        .o_req          (w_dec_req)
    );

    // decouple front from back
    lcdf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_s_tvalid),
        .i_req   (w_dec_req),
        .o_ready (o_s_tready),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_req   (w_q_req)
    );

    // serialise frames
    lcdf_engine u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (w_q_valid),
        .i_req        (w_q_req),
        .o_pop        (w_pop),
        .o_valid      (o_m_tvalid),
        .i_ready      (i_m_tready),
        .o_kind       (o_m_tuser),
        .o_data_bit   (w_bit),
        .o_frame_last (o_m_tlast)
    );

    assign o_m_tdata = {7'b0000000, w_bit};

endmodule
`default_nettype wire

@@ bench/tb_lcd_driver_serial_framer.sv @@
// Self-checking bench for lcd_driver_serial_framer: a directed table, then random frame traffic.
// Each accepted item runs through an in-bench framer predictor; results are checked in order.
// Depends on lcdf_pkg and the lcd_driver_serial_framer top level.
module tb_lcd_driver_serial_framer;

    localparam int unsigned BURST_CAP      = 16;
    localparam int unsigned RANDOM_ITEMS   = 1750;
    localparam int unsigned QUIET_FROM     = 1500;
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned DRAIN_CYCLES   = 16;
    localparam int unsigned MAX_REPORTS    = 10;

    // How a table row gets its expectation
    localparam logic CHK_PRED  = 1'b0;
    localparam logic CHK_TYPED = 1'b1;

    typedef struct packed {
        logic kind;
        logic data_bit;
        logic frame_last;
    } t_bit_res;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] cmd;
        logic [5:0] addr;
        logic [3:0] nib;
        logic [4:0] cnt;
        logic       chk;     // CHK_TYPED: use yields/res below
        logic       yields;  // typed: one result due
        t_bit_res   res;     // typed: its value
    } t_row;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [31:0] s_tdata  = '0;
    logic        m_tready = 1'b1;
    logic        s_tready;
    logic        m_tvalid;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    logic        m_tuser;

    // Predictor state: outgoing bits, bits left in the frame, frame running
    logic [12:0] frame_shift = '0;
    logic [7:0]  bits_left   = '0;
    logic        frame_busy  = 1'b0;
    t_bit_res    expected_bits[$];

    t_row        directed_tab[$];
    t_row        row;
    t_bit_res    want_bit;
    bit          idling_on    = 1'b1;
    int unsigned fail_count   = 0;
    int unsigned quiet_cycles = 0;
    int unsigned stall_left   = 0;
    int unsigned counted      = 0;
    int unsigned pick;

    lcd_driver_serial_framer #(
        .MAX_BURST_BYTES(BURST_CAP)
    ) u_dut (
        .i_clk     (clk),
        .i_rst_n   (rst_n),
        .i_s_tvalid(s_tvalid),
        .o_s_tready(s_tready),
        .i_s_tdata (s_tdata),
        .o_m_tvalid(m_tvalid),
        .i_m_tready(m_tready),
        .o_m_tdata (m_tdata),
        .o_m_tlast (m_tlast),
        .o_m_tuser (m_tuser)
    );

    // Clock, period 10
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic t_row mk_row(logic [1:0] op, logic [7:0] cmd, logic [5:0] addr,
                                    logic [3:0] nib, logic [4:0] cnt, logic chk,
                                    logic yields, logic kind, logic dbit, logic last);
        t_row r;
        r.op = op;
        r.cmd = cmd;
        r.addr = addr;
        r.nib = nib;
        r.cnt = cnt;
        r.chk = chk;
        r.yields = yields;
        r.res.kind = kind;
        r.res.data_bit = dbit;
        r.res.frame_last = last;
        return r;
    endfunction

    // Framer predictor: advances the state by one item, gives its result if any
    task automatic framer_predict(input t_row it, output logic yields, output t_bit_res res);
        logic [4:0] bytes;
        yields = 1'b0;
        res = '0;
        bytes = it.cnt;
        if (it.op == lcdf_pkg::OP_TICK) begin
            if (frame_busy) begin
                yields = 1'b1;
                res.kind = lcdf_pkg::KIND_BIT;
                res.data_bit = frame_shift[12];
                frame_shift = {frame_shift[11:0], 1'b0};
                bits_left = bits_left - 8'd1;
                res.frame_last = (bits_left == 8'd0);
                if (bits_left == 8'd0)
                    frame_busy = 1'b0;
            end
        end else if (frame_busy) begin
            // rejected, running frame untouched
            yields = 1'b1;
            res.kind = lcdf_pkg::KIND_BUSY;
        end else begin
            frame_busy = 1'b1;
            case (it.op)
                lcdf_pkg::OP_COMMAND: begin
                    frame_shift = {lcdf_pkg::CMD_PREFIX, it.cmd, 1'b0};
                    bits_left = lcdf_pkg::CMD_LEN;
                end
                lcdf_pkg::OP_WRITE: begin
                    frame_shift = {lcdf_pkg::WRITE_PREFIX, it.addr, it.nib};
                    bits_left = lcdf_pkg::WRITE_LEN;
                end
                default: begin
                    // byte count saturates to the cap, then to the counter limit
                    if (bytes > BURST_CAP)
                        bytes = 5'(BURST_CAP);
                    if (bytes > lcdf_pkg::COUNTER_BYTE_LIMIT)
                        bytes = 5'(lcdf_pkg::COUNTER_BYTE_LIMIT);
                    frame_shift = {lcdf_pkg::WRITE_PREFIX, it.addr, 4'b0000};
                    bits_left = lcdf_pkg::BURST_HDR + 8'(bytes) * 8'd8;
                end
            endcase
        end
    endtask

    task automatic report_failure(input string msg);
        if (fail_count < MAX_REPORTS)
            $display("%0t: %s", $time, msg);
        fail_count++;
    endtask

    // Offer one item at the falling edge, hold it until accepted, then predict
    task automatic offer_item(input t_row it);
        logic     yields;
        t_bit_res res;
        if (idling_on && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'b0, it.cnt, it.nib, it.addr, it.cmd, it.op};
        do @(posedge clk); while (!s_tready);
        framer_predict(it, yields, res);
        if (it.chk == CHK_TYPED) begin
            yields = it.yields;
            res = it.res;
        end
        if (yields)
            expected_bits.push_back(res);
        @(negedge clk);
    endtask

    // Receiver: random stall bursts, started only while idling is on
    always @(negedge clk) begin
        if (stall_left != 0) begin
            stall_left = stall_left - 1;
            m_tready <= 1'b0;
        end else if (idling_on && rst_n && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 7);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Result checker against the oldest expectation
    always @(posedge clk) begin
        if (rst_n && m_tvalid && m_tready) begin
            if (expected_bits.size() == 0) begin
                report_failure($sformatf("unexpected result: kind=%0b tdata=%02h last=%0b",
                                         m_tuser, m_tdata, m_tlast));
            end else begin
                want_bit = expected_bits.pop_front();
                if (m_tuser !== want_bit.kind || m_tdata !== {7'b0, want_bit.data_bit} ||
                    m_tlast !== want_bit.frame_last)
                    report_failure($sformatf(
                        {"mismatch: expected kind=%0b bit=%0b last=%0b, ",
                         "got kind=%0b tdata=%02h last=%0b"},
                        want_bit.kind, want_bit.data_bit, want_bit.frame_last,
                        m_tuser, m_tdata, m_tlast));
            end
        end
    end

    // Watchdog: cycles with no item moving on either side
    always @(posedge clk) begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    // Stimulus
    initial begin
        // tick while idle is ignored
        directed_tab.push_back(mk_row(lcdf_pkg::OP_TICK, 8'hFF, 6'h3F, 4'hF, 5'd31,
                                      CHK_TYPED, 1'b0, lcdf_pkg::KIND_BIT, 1'b0, 1'b0));
        // burst clear of zero bytes, top address: header only
        directed_tab.push_back(mk_row(lcdf_pkg::OP_BURST, 8'h00, 6'h3F, 4'h0, 5'd0,
                                      CHK_TYPED, 1'b0, lcdf_pkg::KIND_BIT, 1'b0, 1'b0));
        directed_tab.push_back(mk_row(lcdf_pkg::OP_TICK, 8'h00, 6'h00, 4'h0, 5'd0,
                                      CHK_TYPED, 1'b1, lcdf_pkg::KIND_BIT, 1'b1, 1'b0));
        // request while busy
        directed_tab.push_back(mk_row(lcdf_pkg::OP_COMMAND, 8'h00, 6'h00, 4'h0, 5'd0,
                                      CHK_TYPED, 1'b1, lcdf_pkg::KIND_BUSY, 1'b0, 1'b0));
        repeat (7)
            directed_tab.push_back(mk_row(lcdf_pkg::OP_TICK, 8'hA5, 6'h2A, 4'h5, 5'd10,
                                          CHK_PRED, 1'b0, lcdf_pkg::KIND_BIT, 1'b0, 1'b0));
        directed_tab.push_back(mk_row(lcdf_pkg::OP_TICK, 8'h00, 6'h00, 4'h0, 5'd0,
                                      CHK_TYPED, 1'b1, lcdf_pkg::KIND_BIT, 1'b1, 1'b1));
        // write nibble, lowest address, all-ones nibble
        directed_tab.push_back(mk_row(lcdf_pkg::OP_WRITE, 8'hFF, 6'h00, 4'hF, 5'd16,
                                      CHK_TYPED, 1'b0, lcdf_pkg::KIND_BIT, 1'b0, 1'b0));
        directed_tab.push_back(mk_row(lcdf_pkg::OP_BURST, 8'hFF, 6'h3F, 4'hF, 5'd31,
                                      CHK_TYPED, 1'b1, lcdf_pkg::KIND_BUSY, 1'b0, 1'b0));
        repeat (12)
            directed_tab.push_back(mk_row(lcdf_pkg::OP_TICK, 8'h5A, 6'h15, 4'hA, 5'd21,
                                          CHK_PRED, 1'b0, lcdf_pkg::KIND_BIT, 1'b0, 1'b0));
        directed_tab.push_back(mk_row(lcdf_pkg::OP_TICK, 8'h00, 6'h00, 4'h0, 5'd0,
                                      CHK_TYPED, 1'b1, lcdf_pkg::KIND_BIT, 1'b1, 1'b1));
        // oversized burst: saturates; its ticks come from the random part
        directed_tab.push_back(mk_row(lcdf_pkg::OP_BURST, 8'h3C, 6'h2A, 4'h9, 5'd31,
                                      CHK_PRED, 1'b0, lcdf_pkg::KIND_BIT, 1'b0, 1'b0));
        directed_tab.push_back(mk_row(lcdf_pkg::OP_COMMAND, 8'hFF, 6'h3F, 4'hF, 5'd0,
                                      CHK_TYPED, 1'b1, lcdf_pkg::KIND_BUSY, 1'b0, 1'b0));

        // synchronous reset, released at a falling edge
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_tab[i])
            offer_item(directed_tab[i]);

        // random part: mostly complete frames, some rejected requests and idle ticks
        while (counted < RANDOM_ITEMS) begin
            idling_on = (counted < QUIET_FROM) && ((counted / 250) % 4 != 3);
            row.cmd  = 8'($urandom_range(0, 255));
            row.addr = 6'($urandom_range(0, 63));
            row.nib  = 4'($urandom_range(0, 15));
            pick = $urandom_range(0, 99);
            if (!frame_busy)
                row.op = (pick < 8) ? lcdf_pkg::OP_TICK : 2'($urandom_range(1, 3));
            else
                row.op = (pick < 6) ? 2'($urandom_range(1, 3)) : lcdf_pkg::OP_TICK;
            // byte counts mostly small, a few at or past the cap
            pick = $urandom_range(0, 99);
            if (pick < 70)
                row.cnt = 5'($urandom_range(0, 2));
            else if (pick < 96)
                row.cnt = 5'($urandom_range(3, 15));
            else
                row.cnt = 5'($urandom_range(16, 31));
            row.chk = CHK_PRED;
            row.yields = 1'b0;
            row.res = '0;
            if (!(row.op == lcdf_pkg::OP_TICK && !frame_busy))
                counted++;
            offer_item(row);
        end
        s_tvalid <= 1'b0;

        // drain, then let the pipeline settle
        while (expected_bits.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

@@ lcd_driver_serial_framer.f @@
src/lcdf_pkg.sv
src/lcdf_front.sv
src/lcdf_queue.sv
src/lcdf_engine.sv
src/lcd_driver_serial_framer.sv
bench/tb_lcd_driver_serial_framer.sv
